FILE: hw/rtl/k_way_sorted_merge_defines.svh
// assertion macros for the k-way merge checker
// no dependencies
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// same-cycle implication
`define KWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/kwm_pkg.sv
// shared types and constants of the k-way merge
// no dependencies
package kwm_pkg;

   localparam int VALUE_W     = 32;
   localparam int SRC_WAY_W   = 3;
   localparam int OUT_WAY_W   = 3;
   localparam int CFG_W       = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

FILE: hw/rtl/kwm_cell.sv
// one cell of the sorted row: holds one element and its way
// depends on kwm_pkg
module kwm_cell #(
   parameter int WAY_W = 3
) (
   input  logic                               clock,
   input  kwm_pkg::cell_cmd_type              cmd,
   input  logic [WAY_W-1:0]                   new_way,
   input  logic                               occ,
   input  logic                               left_lt,
   input  logic signed [kwm_pkg::VALUE_W-1:0] left_value,
   input  logic [WAY_W-1:0]                   left_way,
   input  logic signed [kwm_pkg::VALUE_W-1:0] right_value,
   input  logic [WAY_W-1:0]                   right_way,
   output logic                               lt,
   output logic signed [kwm_pkg::VALUE_W-1:0] value,
   output logic [WAY_W-1:0]                   way
);

   logic signed [kwm_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [WAY_W-1:0]                   way_ff, way_in;
   logic                               less;

   // new element orders before the held one
   assign less = (cmd.value < value_ff) || ((cmd.value == value_ff) && (new_way < way_ff));
   assign lt   = !occ || less;

   always_comb begin
      value_in = value_ff;
      way_in   = way_ff;
      unique case (cmd.op)
         kwm_pkg::CELL_INSERT: begin
            if (lt) begin
               if (left_lt) begin
                  value_in = left_value;
                  way_in   = left_way;
               end else begin
                  value_in = cmd.value;
                  way_in   = new_way;
               end
            end
         end
         kwm_pkg::CELL_POP: begin
            value_in = right_value;
            way_in   = right_way;
         end
         default: begin
            value_in = value_ff;
            way_in   = way_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      way_ff   <= way_in;
   end

   assign value = value_ff;
   assign way   = way_ff;

endmodule

FILE: hw/rtl/k_way_sorted_merge.sv
// k-way merge of presorted signed streams on a sorted row of cells
// depends on kwm_pkg, kwm_cell
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata source_way, element_value; tuser has_element
// rsp      out  rsp_tvalid/rsp_tready  tdata out_value, out_way; tuser merge_done
// csr      in   csr_valid/csr_ready    csr_wdata ways_in_use
//
// a request goes through accept, insert into the cell row and pop of the head cell
// into the output register; a priming request with no response skips the pop
// the row does at most one insert or one pop a cycle
// the pop waits while the output register holds an unread result
// reset is synchronous: empties the row, restarts priming, ways_in_use = 8
// a csr write empties the row and restarts priming
module k_way_sorted_merge #(
   parameter int WAYS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [kwm_pkg::REQ_TDATA_W-1:0]      req_tdata,  // source_way, element_value
   input  logic                                 req_tuser,  // has_element
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [kwm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // out_value, out_way
   output logic                                 rsp_tuser,  // merge_done
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kwm_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int WAY_W = $clog2(WAYS);
   localparam int CNT_W = $clog2(WAYS + 1);
   localparam int VW    = kwm_pkg::VALUE_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS,
      S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          primed_ff, primed_in;
   logic                      awaiting_ff, awaiting_in;
   logic [WAY_W-1:0]          awaited_ff, awaited_in;
   logic [kwm_pkg::CFG_W-1:0] ways_ff, ways_in;
   logic                      job_ins_ff, job_ins_in;
   logic                      job_emit_ff, job_emit_in;
   logic                      job_done_ff, job_done_in;
   logic signed [VW-1:0]      job_value_ff, job_value_in;
   logic [WAY_W-1:0]          job_way_ff, job_way_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_done_ff, rsp_done_in;
   logic signed [VW-1:0]      rsp_value_ff, rsp_value_in;
   logic [kwm_pkg::OUT_WAY_W-1:0] rsp_way_ff, rsp_way_in;

   logic [CNT_W-1:0]          k_eff;
   logic                      req_acc, csr_acc, out_free;
   logic signed [VW-1:0]      req_value;
   kwm_pkg::cell_cmd_type     cmd;

   logic [WAYS-1:0]           occ;
   logic [WAYS-1:0]           cell_lt;
   logic signed [VW-1:0]      cell_value [WAYS];
   logic [WAY_W-1:0]          cell_way [WAYS];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE) && !req_tvalid;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_value  = req_tdata[kwm_pkg::SRC_WAY_W +: VW];

   always_comb begin
      if (ways_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (int'(ways_ff) > WAYS) begin
         k_eff = CNT_W'(WAYS);
      end else begin
         k_eff = CNT_W'(ways_ff);
      end
   end

   // sorted row, head cell holds the smallest element
   for (genvar i = 0; i < WAYS; i++) begin : g_cell
      logic                 l_lt;
      logic signed [VW-1:0] l_value, r_value;
      logic [WAY_W-1:0]     l_way, r_way;

      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign l_lt    = 1'b0;
         assign l_value = '0;
         assign l_way   = '0;
      end else begin : g_body
         assign l_lt    = cell_lt[i-1];
         assign l_value = cell_value[i-1];
         assign l_way   = cell_way[i-1];
      end

      if (i == WAYS - 1) begin : g_tail
         assign r_value = '0;
         assign r_way   = '0;
      end else begin : g_inner
         assign r_value = cell_value[i+1];
         assign r_way   = cell_way[i+1];
      end

      kwm_cell #(
         .WAY_W (WAY_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .new_way     (job_way_ff),
         .occ         (occ[i]),
         .left_lt     (l_lt),
         .left_value  (l_value),
         .left_way    (l_way),
         .right_value (r_value),
         .right_way   (r_way),
         .lt          (cell_lt[i]),
         .value       (cell_value[i]),
         .way         (cell_way[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      primed_in    = primed_ff;
      awaiting_in  = awaiting_ff;
      awaited_in   = awaited_ff;
      ways_in      = ways_ff;
      job_ins_in   = job_ins_ff;
      job_emit_in  = job_emit_ff;
      job_done_in  = job_done_ff;
      job_value_in = job_value_ff;
      job_way_in   = job_way_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_done_in  = rsp_done_ff;
      rsp_value_in = rsp_value_ff;
      rsp_way_in   = rsp_way_ff;
      cmd.op       = kwm_pkg::CELL_HOLD;
      cmd.value    = job_value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               job_value_in = req_value;
               state_in     = S_INS;
               if (primed_ff < k_eff) begin
                  job_ins_in  = req_tuser;
                  job_way_in  = primed_ff[WAY_W-1:0];
                  primed_in   = primed_ff + CNT_W'(1);
                  job_emit_in = (primed_ff + CNT_W'(1) == k_eff);
                  job_done_in = 1'b0;
               end else if (!awaiting_ff) begin
                  job_ins_in  = 1'b0;
                  job_emit_in = 1'b0;
                  job_done_in = 1'b1;
               end else begin
                  job_ins_in  = req_tuser;
                  job_way_in  = awaited_ff;
                  job_emit_in = 1'b1;
                  job_done_in = 1'b0;
               end
            end else if (csr_acc) begin
               ways_in     = csr_wdata;
               count_in    = '0;
               primed_in   = '0;
               awaiting_in = 1'b0;
            end
         end
         S_INS: begin
            if (job_ins_ff && !occ[WAYS-1]) begin
               cmd.op   = kwm_pkg::CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = (job_emit_ff || job_done_ff) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (!job_done_ff && occ[0]) begin
                  cmd.op       = kwm_pkg::CELL_POP;
                  count_in     = count_ff - CNT_W'(1);
                  awaiting_in  = 1'b1;
                  awaited_in   = cell_way[0];
                  rsp_done_in  = 1'b0;
                  rsp_value_in = cell_value[0];
                  rsp_way_in   = kwm_pkg::OUT_WAY_W'(cell_way[0]);
               end else begin
                  awaiting_in  = 1'b0;
                  rsp_done_in  = 1'b1;
                  rsp_value_in = '0;
                  rsp_way_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         primed_ff    <= '0;
         awaiting_ff  <= 1'b0;
         awaited_ff   <= '0;
         ways_ff      <= kwm_pkg::CFG_RESET;
         job_ins_ff   <= 1'b0;
         job_emit_ff  <= 1'b0;
         job_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         primed_ff    <= primed_in;
         awaiting_ff  <= awaiting_in;
         awaited_ff   <= awaited_in;
         ways_ff      <= ways_in;
         job_ins_ff   <= job_ins_in;
         job_emit_ff  <= job_emit_in;
         job_done_ff  <= job_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_value_ff <= job_value_in;
      job_way_ff   <= job_way_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_value_ff <= rsp_value_in;
      rsp_way_ff   <= rsp_way_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tdata  = {{(kwm_pkg::RSP_TDATA_W - VW - kwm_pkg::OUT_WAY_W){1'b0}},
                        rsp_way_ff, rsp_value_ff};

endmodule

FILE: hw/rtl/kwm_checker.sv
// port-level checks of the k-way merge, bound to the top level
// depends on kwm_pkg, k_way_sorted_merge_defines.svh
`include "k_way_sorted_merge_defines.svh"

module kwm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [kwm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser
);

   logic                          rsp_wait;
   logic                          rsp_is_done;
   logic                          req_take;
   logic                          csr_take;
   logic                          busy;
   logic [kwm_pkg::RSP_TDATA_W+1:0] rsp_bus;

   assign rsp_wait    = rsp_tvalid && !rsp_tready;
   assign rsp_is_done = rsp_tvalid && rsp_tuser;
   assign req_take    = req_tvalid && req_tready;
   assign csr_take    = csr_valid && csr_ready;
   assign busy        = !req_tready && !csr_ready;
   assign rsp_bus     = {rsp_tvalid, rsp_tuser, rsp_tdata};

   `KWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_bus), "response not held")
   `KWM_ASSERT_NOW(a_done_zero, clock, reset, rsp_is_done, rsp_tdata == '0, "done carries data")
   `KWM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_take, busy, "ready during work")
   `KWM_ASSERT_NOW(a_rsp_src, clock, reset, $rose(rsp_tvalid), $past(busy), "stray response")
   `KWM_ASSERT_NOW(a_csr_alone, clock, reset, csr_take, !req_take, "csr write beside request")

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: sim/kwm_merge_checker.sv
// result checker for k_way_sorted_merge: watches the request, response and csr channels
// keeps its own merge state and compares every response; depends on kwm_pkg
module kwm_merge_checker #(
   parameter int WAYS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [kwm_pkg::REQ_TDATA_W-1:0]  req_tdata,  // source_way, element_value
   input  logic                             req_tuser,  // has_element
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [kwm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // out_value, out_way
   input  logic                             rsp_tuser,  // merge_done
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [kwm_pkg::CFG_W-1:0]        csr_wdata,
   output int                               error_count,
   output int                               pending_count
);
   import kwm_pkg::*;

   typedef struct packed {
      logic                       done;
      logic signed [VALUE_W-1:0]  value;
      logic [OUT_WAY_W-1:0]       way;
   } merge_out_type;

   merge_out_type              merge_out_q[$];
   logic signed [VALUE_W-1:0]  held_value[WAYS];
   int                         held_way[WAYS];
   int                         held_count;
   int                         primed_count;
   int                         awaited_way;
   logic                       awaiting;
   logic [CFG_W-1:0]           ways_cfg;

   task automatic restart_merge();
      held_count   = 0;
      primed_count = 0;
      awaiting     = 1'b0;
      awaited_way  = 0;
   endtask

   task automatic hold_element(input logic signed [VALUE_W-1:0] value, input int way);
      if (held_count < WAYS) begin
         held_value[held_count] = value;
         held_way[held_count]   = way;
         held_count++;
      end
   endtask

   task automatic push_done();
      merge_out_type r;
      r.done  = 1'b1;
      r.value = '0;
      r.way   = '0;
      merge_out_q.insert(merge_out_q.size(), r);
      awaiting = 1'b0;
   endtask

   // smallest value wins, lower way on a tie
   task automatic pop_smallest();
      merge_out_type r;
      int best;
      int i;
      if (held_count == 0) begin
         push_done();
         return;
      end
      best = 0;
      for (i = 1; i < held_count; i++)
         if (held_value[i] < held_value[best] ||
             (held_value[i] == held_value[best] && held_way[i] < held_way[best]))
            best = i;
      r.done  = 1'b0;
      r.value = held_value[best];
      r.way   = OUT_WAY_W'(held_way[best]);
      merge_out_q.insert(merge_out_q.size(), r);
      awaiting    = 1'b1;
      awaited_way = held_way[best];
      held_count--;
      held_value[best] = held_value[held_count];
      held_way[best]   = held_way[held_count];
   endtask

   task automatic predict_request(input logic has, input logic signed [VALUE_W-1:0] value);
      int k;
      k = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : int'(ways_cfg));
      if (primed_count < k) begin
         if (has)
            hold_element(value, primed_count);
         primed_count++;
         if (primed_count == k)
            pop_smallest();
      end else if (!awaiting) begin
         push_done();
      end else begin
         if (has)
            hold_element(value, awaited_way);
         pop_smallest();
      end
   endtask

   task automatic report(input string what, input merge_out_type want,
                         input merge_out_type got);
      error_count++;
      if (error_count <= 10)
         $display("merge mismatch (%s): expected %0b/%0d/%0d, got %0b/%0d/%0d",
                  what, want.done, want.value, want.way, got.done, got.value, got.way);
   endtask

   task automatic check_response();
      merge_out_type got;
      merge_out_type want;
      got.done  = rsp_tuser;
      got.value = rsp_tdata[VALUE_W-1:0];
      got.way   = rsp_tdata[VALUE_W +: OUT_WAY_W];
      if (merge_out_q.size() == 0) begin
         report("no request pending", got, got);
         return;
      end
      want = merge_out_q.pop_front();
      if (got.done !== want.done || got.value !== want.value || got.way !== want.way)
         report("wrong field", want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ways_cfg    = CFG_RESET;
         error_count = 0;
         restart_merge();
         merge_out_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response();
         if (csr_valid && csr_ready) begin
            ways_cfg = csr_wdata;
            restart_merge();
         end
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata[SRC_WAY_W +: VALUE_W]);
      end
      pending_count = merge_out_q.size();
   end

endmodule

FILE: sim/tb_top.sv
// testbench top for k_way_sorted_merge: builds sorted streams, drives requests and csr writes
// with random gaps and stalls, and gives the verdict; depends on kwm_pkg and kwm_merge_checker
module tb_top;
   import kwm_pkg::*;

   localparam int WAYS          = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1300;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CFG_W-1:0]        csr_wdata = '0;

   int                      error_count;
   int                      pending_count;
   int                      request_count = 0;
   int                      response_count = 0;
   int                      response_target = 0;
   int                      ways_cfg = 8;
   logic                    last_done = 1'b0;
   logic [OUT_WAY_W-1:0]    last_way = '0;
   bit                      calm = 1'b0;

   logic signed [VALUE_W-1:0]  stream_head[WAYS];
   logic signed [VALUE_W-1:0]  stream_last[WAYS];
   int                         stream_len[WAYS];

   k_way_sorted_merge #(.WAYS(WAYS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   kwm_merge_checker #(.WAYS(WAYS)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // the refill depends on the way just emitted
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         response_count++;
         last_done = rsp_tuser;
         last_way  = rsp_tdata[VALUE_W +: OUT_WAY_W];
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3:    return $signed($urandom_range(0, 40)) - 20;
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] next_element(
      input logic signed [VALUE_W-1:0] last, input int noise_pct);
      longint n;
      if ($urandom_range(0, 99) < noise_pct)
         return $signed($urandom);
      case ($urandom_range(0, 3))
         0:       n = longint'(last);
         1:       n = longint'(last) + longint'($urandom_range(1, 4));
         2:       n = longint'(last) + longint'($urandom_range(1, 1000));
         default: n = longint'(last) + longint'($urandom);
      endcase
      if (n > 64'sd2147483647)
         n = 64'sd2147483647;
      return n[VALUE_W-1:0];
   endfunction

   initial begin : rsp_stall
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall = gap_len();
         end
      end
   end

   // leaves tvalid high after the request is taken
   task automatic send_req(input logic has, input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = (!calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= has;
      req_tdata  <= {5'b0, value, SRC_WAY_W'($urandom)};
      do @(posedge clock); while (!req_tready);
      request_count++;
   endtask

   task automatic wait_response();
      response_target++;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (response_count < response_target) @(negedge clock);
   endtask

   task automatic write_ways(input logic [CFG_W-1:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      ways_cfg = int'(v);
   endtask

   // stream_len counts the head too; abort_after < 0 runs until done
   task automatic run_merge(input int abort_after, input int noise_pct);
      int k;
      int w;
      int emitted;
      logic signed [VALUE_W-1:0] v;
      k = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);
      for (w = 0; w < k; w++) begin
         stream_last[w] = stream_head[w];
         send_req(stream_len[w] > 0, (stream_len[w] > 0) ? stream_head[w] : $signed($urandom));
         if (stream_len[w] > 0)
            stream_len[w]--;
      end
      wait_response();
      emitted = 1;
      while (!last_done && emitted != abort_after) begin
         w = last_way;
         if (stream_len[w] > 0) begin
            v = next_element(stream_last[w], noise_pct);
            stream_last[w] = v;
            stream_len[w]--;
            send_req(1'b1, v);
         end else begin
            send_req(1'b0, $signed($urandom));
         end
         wait_response();
         emitted++;
      end
      // requests after done just repeat the done response
      if (last_done) begin
         repeat ($urandom_range(0, 2)) begin
            send_req(1'($urandom), $signed($urandom));
            wait_response();
         end
      end
   endtask

   initial begin : stimulus
      int w;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset width, extremes, a tie and empty ways
      stream_head = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 0, 0, 1, 0};
      stream_len  = '{1, 1, 1, 1, 0, 1, 1, 0};
      run_merge(-1, 0);

      // restart in the middle of priming
      write_ways(4'd4);
      send_req(1'b1, -5);
      send_req(1'b1, 7);
      write_ways(4'd0);
      stream_head[0] = 32'sh7fff_fff0;
      stream_len[0]  = 3;
      run_merge(-1, 0);

      // every way empty
      write_ways(4'd15);
      for (w = 0; w < WAYS; w++)
         stream_len[w] = 0;
      run_merge(-1, 0);

      while (request_count < RANDOM_ITEMS) begin
         write_ways(CFG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(2, 8)));
         calm = ($urandom_range(0, 4) == 0);
         for (w = 0; w < WAYS; w++) begin
            stream_head[w] = random_value();
            stream_len[w]  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         end
         run_merge(($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1,
                   ($urandom_range(0, 9) == 0) ? 30 : 0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
